/* rtl/bps_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// bps_pkg
// Shared types and constants of the Bezier path smoother.
// ---------------------------------------------------------------------------
package bps_pkg;

  localparam int unsigned CtrlW        = 7;
  localparam int unsigned ParamW       = 17;
  localparam int unsigned InDataW      = 88;
  localparam int unsigned OutDataW     = 64;
  localparam int unsigned MinPoints    = 4;
  localparam logic [CtrlW-1:0] CtrlCountReset = 7'd20;
  localparam logic [ParamW-1:0] TOne  = 17'd65536;

  localparam logic [1:0] ModeStart  = 2'd0;
  localparam logic [1:0] ModeAppend = 2'd1;
  localparam logic [1:0] ModeEval   = 2'd2;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StTooFew   = 2'd1;
  localparam logic [1:0] StOverflow = 2'd2;

  localparam logic RegCtrlCount = 1'b0;

  typedef enum logic [12:0] {
    StIdle   = 13'b0000000000001,
    StStore  = 13'b0000000000010,
    StCheck  = 13'b0000000000100,
    StDiv    = 13'b0000000001000,
    StCpRd   = 13'b0000000010000,
    StCpWr   = 13'b0000000100000,
    StRdA    = 13'b0000001000000,
    StLdA    = 13'b0000010000000,
    StRdB    = 13'b0000100000000,
    StLdB    = 13'b0001000000000,
    StMul    = 13'b0010000000000,
    StWr     = 13'b0100000000000,
    StResult = 13'b1000000000000
  } state_e;

  typedef struct packed {
    logic in_load;
    logic store;
    logic res_ovf;
    logic res_short;
    logic div_start;
    logic div_step;
    logic cp_first;
    logic cp_wr;
    logic rd_a;
    logic ld_a;
    logic ld_b;
    logic mul;
    logic wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic ovf;
    logic short_path;
    logic div_busy;
    logic cp_last;
    logic pass_end;
    logic final_pass;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* rtl/bps_ram.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// bps_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/bps_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// bps_ctrl
// Sequencer: input transfer, store, control point selection, de Casteljau.
// ---------------------------------------------------------------------------
module bps_ctrl import bps_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_tvalid_i,
  output logic            s_tready_o,
  input  wire logic [1:0] mode_i,
  input  wire status_t    status_i,
  output cmd_t            cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.in_load = 1'b1;
          case (mode_i) inside
            ModeStart, ModeAppend: state_d = StStore;
            ModeEval:              state_d = StCheck;
            default:               state_d = StIdle;
          endcase
        end
      end
      StStore: begin
        cmd_o.store = 1'b1;
        state_d     = StIdle;
      end
      StCheck: begin
        if (status_i.ovf) begin
          cmd_o.res_ovf = 1'b1;
          state_d       = StResult;
        end else if (status_i.short_path) begin
          cmd_o.res_short = 1'b1;
          state_d         = StResult;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = StDiv;
        end
      end
      StDiv: begin
        if (status_i.div_busy) begin
          cmd_o.div_step = 1'b1;
        end else begin
          cmd_o.cp_first = 1'b1;
          state_d        = StCpRd;
        end
      end
      StCpRd: state_d = StCpWr;
      StCpWr: begin
        cmd_o.cp_wr = 1'b1;
        state_d     = status_i.cp_last ? StRdA : StCpRd;
      end
      StRdA: begin
        cmd_o.rd_a = 1'b1;
        state_d    = StLdA;
      end
      StLdA: begin
        cmd_o.ld_a = 1'b1;
        state_d    = StRdB;
      end
      StRdB: state_d = StLdB;
      StLdB: begin
        cmd_o.ld_b = 1'b1;
        state_d    = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StWr;
      end
      StWr: begin
        cmd_o.wr = 1'b1;
        if (status_i.pass_end && status_i.final_pass) begin
          state_d = StResult;
        end else if (status_i.pass_end) begin
          state_d = StRdA;
        end else begin
          state_d = StRdB;
        end
      end
      StResult: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/bps_dp.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// bps_dp
// Datapath: path store, divider, control point copy, lerp unit, output stage.
// ---------------------------------------------------------------------------
module bps_dp import bps_pkg::*; #(
  parameter int unsigned MaxPathPoints = 64,
  parameter int unsigned CoordWidth    = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output status_t                  status_o,
  input  wire logic [InDataW-1:0]  s_tdata_i,
  input  wire logic [1:0]          s_mode_i,
  input  wire logic [CtrlW-1:0]    ctrl_count_i,
  output logic                     m_tvalid_o,
  input  wire logic                m_tready_i,
  output logic [OutDataW-1:0]      m_tdata_o,
  output logic [1:0]               m_tuser_o
);

  localparam int unsigned LenW      = $clog2(MaxPathPoints + 1);
  localparam int unsigned AddrW     = $clog2(MaxPathPoints);
  localparam int unsigned WorkDepth = MaxPathPoints + 1;
  localparam int unsigned WorkAddrW = $clog2(WorkDepth);
  localparam int unsigned CntW      = $clog2(MaxPathPoints + 2);
  localparam int unsigned NumW      = (LenW > CtrlW) ? LenW : CtrlW;
  localparam int unsigned DivCntW   = $clog2(LenW + 1);
  localparam int unsigned ProdW     = CoordWidth + 19;
  localparam int unsigned PairW     = 2 * CoordWidth;

  function automatic logic [31:0] sat32(input logic signed [CoordWidth-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    if (w > 64'sh0000_0000_7fff_ffff) begin
      return 32'h7fff_ffff;
    end else if (w < -64'sh0000_0000_8000_0000) begin
      return 32'h8000_0000;
    end
    return w[31:0];
  endfunction

  // input capture
  logic [1:0]                   mode_q;
  logic signed [CoordWidth-1:0] px_q, py_q;
  logic [ParamW-1:0]            t_q;
  logic [ParamW-1:0]            t_in;

  assign t_in = s_tdata_i[80:64];

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      mode_q <= s_mode_i;
      px_q   <= CoordWidth'(signed'(s_tdata_i[31:0]));
      py_q   <= CoordWidth'(signed'(s_tdata_i[63:32]));
      t_q    <= (t_in > TOne) ? TOne : t_in;
    end
  end

  // path store
  logic [LenW-1:0]  len_q, len_d;
  logic             ovf_q, ovf_d;
  logic             path_we;
  logic [AddrW-1:0] path_waddr;
  logic [LenW-1:0]  src_q, src_d;
  logic [PairW-1:0] path_rdata;

  always_comb begin
    len_d      = len_q;
    ovf_d      = ovf_q;
    path_we    = 1'b0;
    path_waddr = len_q[AddrW-1:0];
    if (cmd_i.store) begin
      if (mode_q == ModeStart) begin
        len_d      = LenW'(1);
        ovf_d      = 1'b0;
        path_we    = 1'b1;
        path_waddr = '0;
      end else if (len_q < LenW'(MaxPathPoints)) begin
        len_d   = len_q + 1'b1;
        path_we = 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
    end
  end

  bps_ram #(
    .Width (PairW),
    .Depth (MaxPathPoints)
  ) u_path_ram (
    .clk_i   (clk_i),
    .we_i    (path_we),
    .waddr_i (path_waddr),
    .wdata_i ({py_q, px_q}),
    .raddr_i (src_q[AddrW-1:0]),
    .rdata_o (path_rdata)
  );

  // control count and step divider
  logic [NumW-1:0]    cc_ext, len_ext, n_sel;
  logic [LenW-1:0]    n_q, dvs_q, quo_q;
  logic [LenW:0]      rem_q, rem_sh;
  logic [DivCntW-1:0] dcnt_q;

  always_comb begin
    cc_ext  = NumW'(ctrl_count_i);
    len_ext = NumW'(len_q);
    n_sel   = (cc_ext == '0) ? len_ext : cc_ext;
    if (n_sel > len_ext) begin
      n_sel = len_ext;
    end
    if (n_sel < NumW'(2)) begin
      n_sel = NumW'(2);
    end
  end

  assign rem_sh = {rem_q[LenW-1:0], quo_q[LenW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= DivCntW'(LenW);
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      n_q   <= LenW'(n_sel);
      dvs_q <= LenW'(n_sel) - 1'b1;
      quo_q <= len_q - 1'b1;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_q <= rem_sh - {1'b0, dvs_q};
        quo_q <= {quo_q[LenW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[LenW-2:0], 1'b0};
      end
    end
  end

  // control point copy and de Casteljau counters
  logic [LenW-1:0] i_q;
  logic [LenW:0]   idx_q;
  logic [CntW-1:0] m_q, k_q, j_q, j_inc;
  logic            last_q;

  assign j_inc = j_q + 1'b1;

  always_comb begin
    src_d = src_q;
    if (cmd_i.cp_first) begin
      src_d = '0;
    end else if (cmd_i.cp_wr && !last_q) begin
      if (i_q < n_q && idx_q < {1'b0, len_q}) begin
        src_d = idx_q[LenW-1:0];
      end else begin
        src_d = len_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    if (cmd_i.cp_first) begin
      i_q    <= LenW'(1);
      idx_q  <= {1'b0, quo_q};
      m_q    <= '0;
      last_q <= 1'b0;
    end else if (cmd_i.cp_wr) begin
      m_q <= m_q + 1'b1;
      if (last_q) begin
        k_q <= m_q;
        j_q <= '0;
      end else if (i_q < n_q && idx_q < {1'b0, len_q}) begin
        i_q   <= i_q + 1'b1;
        idx_q <= idx_q + {1'b0, quo_q};
      end else begin
        last_q <= 1'b1;
      end
    end else if (cmd_i.wr) begin
      if (j_inc == k_q) begin
        k_q <= k_q - 1'b1;
        j_q <= '0;
      end else begin
        j_q <= j_inc;
      end
    end
  end

  // work store and lerp unit
  logic                         work_we;
  logic [WorkAddrW-1:0]         work_waddr, work_raddr;
  logic [PairW-1:0]             work_wdata, work_rdata;
  logic signed [CoordWidth-1:0] ax_q, ay_q, bx_q, by_q, rx, ry;
  logic signed [CoordWidth:0]   dx_q, dy_q, sum_x, sum_y;
  logic signed [ProdW-1:0]      prx_q, pry_q, rnd_x, rnd_y;
  logic signed [17:0]           t_s;
  logic signed [CoordWidth-1:0] new_x, new_y;

  assign t_s = signed'({1'b0, t_q});
  assign rx  = signed'(work_rdata[CoordWidth-1:0]);
  assign ry  = signed'(work_rdata[PairW-1:CoordWidth]);

  assign rnd_x = (prx_q + ProdW'(32768)) >>> 16;
  assign rnd_y = (pry_q + ProdW'(32768)) >>> 16;
  assign sum_x = (CoordWidth + 1)'(ax_q) + rnd_x[CoordWidth:0];
  assign sum_y = (CoordWidth + 1)'(ay_q) + rnd_y[CoordWidth:0];
  assign new_x = sum_x[CoordWidth-1:0];
  assign new_y = sum_y[CoordWidth-1:0];

  assign work_raddr = cmd_i.rd_a ? '0 : j_inc[WorkAddrW-1:0];

  always_comb begin
    work_we    = 1'b0;
    work_waddr = m_q[WorkAddrW-1:0];
    work_wdata = path_rdata;
    if (cmd_i.cp_wr) begin
      work_we = 1'b1;
    end else if (cmd_i.wr) begin
      work_we    = 1'b1;
      work_waddr = j_q[WorkAddrW-1:0];
      work_wdata = {new_y, new_x};
    end
  end

  bps_ram #(
    .Width (PairW),
    .Depth (WorkDepth)
  ) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (work_we),
    .waddr_i (work_waddr),
    .wdata_i (work_wdata),
    .raddr_i (work_raddr),
    .rdata_o (work_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_a) begin
      ax_q <= rx;
      ay_q <= ry;
    end
    if (cmd_i.ld_b) begin
      bx_q <= rx;
      by_q <= ry;
      dx_q <= (CoordWidth + 1)'(rx) - (CoordWidth + 1)'(ax_q);
      dy_q <= (CoordWidth + 1)'(ry) - (CoordWidth + 1)'(ay_q);
    end
    if (cmd_i.mul) begin
      prx_q <= dx_q * t_s;
      pry_q <= dy_q * t_s;
    end
    if (cmd_i.wr) begin
      ax_q <= bx_q;
      ay_q <= by_q;
    end
  end

  // result and output register
  logic [31:0] res_x_q, res_y_q;
  logic [1:0]  res_st_q;
  logic        m_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ovf || cmd_i.res_short) begin
      res_x_q  <= '0;
      res_y_q  <= '0;
      res_st_q <= cmd_i.res_ovf ? StOverflow : StTooFew;
    end else if (cmd_i.wr && j_inc == k_q && k_q == CntW'(1)) begin
      res_x_q  <= sat32(new_x);
      res_y_q  <= sat32(new_y);
      res_st_q <= StOk;
    end
    if (cmd_i.out_load) begin
      m_tdata_o <= {res_y_q, res_x_q};
      m_tuser_o <= res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_tvalid_o = m_valid_q;

  assign status_o.ovf        = ovf_q;
  assign status_o.short_path = len_q < LenW'(MinPoints);
  assign status_o.div_busy   = dcnt_q != '0;
  assign status_o.cp_last    = last_q;
  assign status_o.pass_end   = j_inc == k_q;
  assign status_o.final_pass = k_q == CntW'(1);
  assign status_o.out_free   = !m_valid_q || m_tready_i;

endmodule
`default_nettype wire

/* rtl/bezier_path_smoother_top.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// bezier_path_smoother_top
// Path point store and Bezier curve evaluation over sampled control points.
// ---------------------------------------------------------------------------
// Input stream: tuser carries the mode. Mode 0 starts a path with the point,
// mode 1 appends it, mode 2 evaluates the curve at curve_param, mode 3 is
// ignored. Only mode 2 produces an output transfer (curve point and status).
// An evaluation runs the step divider, copies the sampled control points,
// then runs the lerps of the de Casteljau triangle pass by pass over m
// curve points (the sampled points plus the last one). Every lerp goes
// through the single read port of the work RAM and one multiplier per axis.
// Early results (too few points, overflow) skip the divider and the lerps.
// Reset empties the path, clears overflow and sets control_count to 20.
// A finished result waits in the output register while the receiver stalls;
// new points are accepted meanwhile, a further evaluation waits for the slot.
// ---------------------------------------------------------------------------
module bezier_path_smoother_top import bps_pkg::*; #(
  parameter int unsigned MaxPathPoints = 64,
  parameter int unsigned CoordWidth    = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [31:0] point_x, [63:32] point_y, [80:64] curve_param, [87:81] zero
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // [1:0] mode
  input  wire logic [1:0]          s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [31:0] curve_x, [63:32] curve_y
  output logic [OutDataW-1:0]      m_axis_tdata,
  // [1:0] status
  output logic [1:0]               m_axis_tuser,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [CtrlW-1:0] ctrl_count_q;
  cmd_t             cmd;
  status_t          status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegCtrlCount) ? 32'(ctrl_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_count_q <= CtrlCountReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegCtrlCount) begin
      ctrl_count_q <= pwdata[CtrlW-1:0];
    end
  end

  bps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .mode_i     (s_axis_tuser),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bps_dp #(
    .MaxPathPoints (MaxPathPoints),
    .CoordWidth    (CoordWidth)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .s_tdata_i    (s_axis_tdata),
    .s_mode_i     (s_axis_tuser),
    .ctrl_count_i (ctrl_count_q),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_o    (m_axis_tdata),
    .m_tuser_o    (m_axis_tuser)
  );

endmodule
`default_nettype wire

/* tb/bezier_path_smoother_chk.sv */
// ---------------------------------------------------------------------------
// bezier_path_smoother_chk
// Watches the input, output and register channels of the path smoother,
// keeps its own copy of the path store and control count, predicts every
// curve point and compares each output transfer against the oldest forecast.
// ---------------------------------------------------------------------------
module bezier_path_smoother_chk import bps_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  input  wire logic                s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  input  wire logic [1:0]          s_axis_tuser,
  input  wire logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  input  wire logic [OutDataW-1:0] m_axis_tdata,
  input  wire logic [1:0]          m_axis_tuser,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output int                       errors_o,
  output int                       pending_o,
  output int                       evals_o
);

  localparam int Depth = 64;

  typedef struct {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [1:0]  st;
  } curve_pt_t;

  longint    px [Depth];
  longint    py [Depth];
  int        plen;
  bit        ovf;
  int        ctrl;
  curve_pt_t curve_q [$];

  function automatic longint lerp_q16(longint a, longint b, longint t);
    longint d, lo, hi;
    d  = b - a;
    lo = d & 64'hFFFF;
    hi = (d - lo) / 65536;
    return a + hi * t + ((lo * t + 32768) / 65536);
  endfunction

  function automatic curve_pt_t curve_at(logic [16:0] tp);
    curve_pt_t r;
    longint wx [Depth+2];
    longint wy [Depth+2];
    int n, stp, m, idx;
    longint t;
    r.cx = '0;
    r.cy = '0;
    if (ovf) begin
      r.st = StOverflow;
      return r;
    end
    if (plen < MinPoints) begin
      r.st = StTooFew;
      return r;
    end
    n = (ctrl == 0) ? plen : ctrl;
    if (n > plen) n = plen;
    if (n < 2) n = 2;
    stp = (plen - 1) / (n - 1);
    m = 1;
    wx[0] = px[0];
    wy[0] = py[0];
    for (int i = 1; i < n; i++) begin
      idx = i * stp;
      if (idx >= plen) break;
      wx[m] = px[idx];
      wy[m] = py[idx];
      m++;
    end
    wx[m] = px[plen-1];
    wy[m] = py[plen-1];
    m++;
    t = (tp > TOne) ? 65536 : longint'(tp);
    for (int k = m - 1; k > 0; k--) begin
      for (int i = 0; i < k; i++) begin
        wx[i] = lerp_q16(wx[i], wx[i+1], t);
        wy[i] = lerp_q16(wy[i], wy[i+1], t);
      end
    end
    r.cx = wx[0][31:0];
    r.cy = wy[0][31:0];
    r.st = StOk;
    return r;
  endfunction

  initial begin
    errors_o = 0;
    evals_o  = 0;
    plen     = 0;
    ovf      = 0;
    ctrl     = CtrlCountReset;
  end

  assign pending_o = curve_q.size();

  // Handshakes settle mid-cycle; a transfer seen here completes at the next edge.
  always @(negedge clk_i) begin
    curve_pt_t e;
    if (rst_ni) begin
      if (psel && penable && pwrite && paddr == 3'(RegCtrlCount))
        ctrl = int'(pwdata[CtrlW-1:0]);
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          ModeStart, ModeAppend: begin
            if (s_axis_tuser == ModeStart) begin
              plen = 0;
              ovf  = 0;
            end
            if (plen < Depth) begin
              px[plen] = longint'(signed'(s_axis_tdata[31:0]));
              py[plen] = longint'(signed'(s_axis_tdata[63:32]));
              plen++;
            end else begin
              ovf = 1;
            end
          end
          ModeEval: begin
            curve_q.insert(curve_q.size(), curve_at(s_axis_tdata[80:64]));
            evals_o++;
          end
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (curve_q.size() == 0) begin
          $error("output transfer with no evaluation pending");
          errors_o++;
        end else begin
          e = curve_q.pop_front();
          if (m_axis_tdata[31:0] !== e.cx) begin
            $error("curve_x expected %h actual %h", e.cx, m_axis_tdata[31:0]);
            errors_o++;
          end
          if (m_axis_tdata[63:32] !== e.cy) begin
            $error("curve_y expected %h actual %h", e.cy, m_axis_tdata[63:32]);
            errors_o++;
          end
          if (m_axis_tuser !== e.st) begin
            $error("status expected %0d actual %0d", e.st, m_axis_tuser);
            errors_o++;
          end
        end
      end
    end
  end

endmodule

/* tb/tb_bezier_path_smoother_top.sv */
// ---------------------------------------------------------------------------
// tb_bezier_path_smoother_top
// Drives path loads and curve evaluations into the smoother under several
// control counts, with random gaps on both streams, and reports the verdict.
// ---------------------------------------------------------------------------
module tb_bezier_path_smoother_top;
  import bps_pkg::*;

  localparam logic [1:0] ModeSpare = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                psel, penable, pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata, prdata;
  logic                pready;
  int                  errors, pending, evals;
  int                  sent;
  bit                  calm;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bezier_path_smoother_top uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  bezier_path_smoother_chk chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata,
    .errors_o(errors), .pending_o(pending), .evals_o(evals)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 11);
  end

  initial begin
    #1_000_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'($signed($urandom_range(2000)) - 1000) << 16;
      default: return $urandom;
    endcase
  endfunction

  task automatic transfer(logic [1:0] mode, logic [31:0] x, logic [31:0] y,
                          logic [16:0] t);
    bit rdy;
    if (!calm && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {7'd0, t, y, x};
    forever begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
      if (rdy) break;
    end
    sent++;
  endtask

  task automatic eval_at();
    logic [16:0] t;
    case ($urandom_range(9))
      0:       t = 17'd0;
      1:       t = TOne;
      2:       t = 17'($urandom_range(131071, 65537));
      default: t = 17'($urandom_range(65536));
    endcase
    transfer(ModeEval, $urandom, $urandom, t);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(RegCtrlCount);
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_path();
    int len;
    case ($urandom_range(9))
      0:       len = $urandom_range(3, 1);
      1:       len = $urandom_range(70, 60);
      default: len = $urandom_range(12, 4);
    endcase
    transfer(ModeStart, rand_coord(), rand_coord(), 17'($urandom));
    for (int i = 1; i < len; i++) begin
      transfer(ModeAppend, rand_coord(), rand_coord(), 17'($urandom));
      if ($urandom_range(99) < 8) eval_at();
    end
    repeat ($urandom_range(3, 1)) eval_at();
  endtask

  initial begin
    int ctrl_set [9] = '{0, 64, 1, 2, 3, 5, 20, 64, 0};
    int phase_len;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ModeStart;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    m_axis_tready <= 1'b1;
    sent  = 0;
    calm  = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty store, append into empty store, extremes, spare mode
    transfer(ModeEval, '0, '0, 17'd0);
    transfer(ModeAppend, 32'h7FFF_FFFF, 32'h8000_0000, '0);
    transfer(ModeAppend, 32'h8000_0000, 32'h7FFF_FFFF, '0);
    transfer(ModeAppend, 32'h0001_0000, 32'hFFFF_0000, '0);
    transfer(ModeEval, '0, '0, 17'd32768);
    transfer(ModeAppend, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
    transfer(ModeEval, '0, '0, 17'd0);
    transfer(ModeEval, '0, '0, TOne);
    transfer(ModeEval, '0, '0, 17'h1FFFF);
    transfer(ModeEval, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd1);
    transfer(ModeSpare, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h1FFFF);
    transfer(ModeEval, '0, '0, 17'd65535);
    transfer(ModeStart, 32'h8000_0000, 32'h8000_0000, '0);
    transfer(ModeAppend, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
    transfer(ModeAppend, 32'h8000_0000, 32'h7FFF_FFFF, '0);
    transfer(ModeAppend, 32'h7FFF_FFFF, 32'h8000_0000, '0);
    transfer(ModeEval, '0, '0, 17'd21845);
    // hold the sender until the smoother has caught up
    drain();

    foreach (ctrl_set[p]) begin
      reg_write(32'(ctrl_set[p]));
      phase_len = sent + 200;
      calm = (p == 4);
      while (sent < phase_len) begin
        case ($urandom_range(9))
          0:       transfer(ModeSpare, $urandom, $urandom, 17'($urandom));
          1:       eval_at();
          2:       transfer(ModeAppend, rand_coord(), rand_coord(), 17'($urandom));
          default: random_path();
        endcase
      end
      drain();
    end
    calm = 1'b0;

    $display("covered %0d input transfers, %0d evaluations, 9 control counts",
             sent, evals);
    $display("paths short, mid-length and overflowing; t from 0 past one");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
